@@ src/sti_pkg.sv @@
package sti_pkg;

    // action codes
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_FWD  = 2'd1;
    localparam logic [1:0] ACT_INV  = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_LOW    = 3'd1;
    localparam logic [2:0] ST_HIGH   = 3'd2;
    localparam logic [2:0] ST_EMPTY  = 3'd3;
    localparam logic [2:0] ST_REJECT = 3'd4;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] query;
        logic [31:0] entry_temp;
        logic [31:0] entry_value;
    } req_t;

    typedef struct packed {
        logic [31:0] answer;
        logic [2:0]  status;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD_LO,
        S_RD_HI,
        S_CHK,
        S_BIS,
        S_CMP,
        S_PREP,
        S_MUL,
        S_DIV,
        S_FIN,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        RD_LO,
        RD_HI,
        RD_MID
    } rd_sel_t;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_REJECT,
        RES_EMPTY,
        RES_LOW,
        RES_HIGH,
        RES_LO_OK,
        RES_INTERP
    } res_t;

    typedef struct packed {
        logic    ready;
        logic    accept;
        logic    write_en;
        logic    init_bounds;
        rd_sel_t rd_sel;
        logic    cap_lo;
        logic    cap_hi;
        logic    set_mid;
        logic    bis_step;
        logic    prep;
        logic    div_start;
        logic    div_step;
        logic    set_res;
        res_t    res_sel;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       full;
        logic       empty;
        logic       below;
        logic       above;
        logic       single;
        logic       more;
        logic       zero_span;
        logic       div_last;
        logic       out_free;
    } sts_t;

endpackage

@@ src/sorted_table_interpolator.sv @@
// Sorted table interpolator: a (temperature, value) table with lookups.
// Request channel (req_valid / req_stall / req): one beat per item. Action
// load appends one entry at the end of the table; a load into a full table
// is refused with status "load rejected". Forward lookup bisects the
// temperature column, inverse lookup the value column, clamps to the end
// entries outside the range and interpolates linearly between neighbours.
// Response channel (rsp_valid / rsp_stall / rsp): exactly one beat per item.
// One item is in work at a time. A load or an idle action goes from
// decode straight to the response beat; a lookup that is clamped ends
// after the end entries are read and checked, and an interpolating one
// runs the bisection and then the divider. Lookup time is set by the
// single read port of each table RAM (a midpoint read and a compare per
// bisection step) and by the divider, which retires one quotient bit per
// cycle.
// Reset empties the table (entry count to zero) and drops any pending
// beat; the RAM contents are left as they are and never read before
// they are written. While rsp_stall is high the response beat holds, and
// a new request is taken but its result waits until the beat goes.
module sorted_table_interpolator #(
    parameter int TABLE_DEPTH = 4096,
    parameter int VALUE_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  sti_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output sti_pkg::rsp_t rsp
);

    sti_pkg::cmd_t cmd;
    sti_pkg::sts_t sts;

    // sequencer: decode, bisection steps, divide iterations, response hand-off
    sti_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    // table RAMs, search bounds, interpolation arithmetic, response register
    sti_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    // take a request only while the sequencer is waiting for one
    assign req_stall = !cmd.ready;

endmodule

@@ src/sti_ram.sv @@
module sti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/sti_datapath.sv @@
module sti_datapath #(
    parameter int TABLE_DEPTH = 4096,
    parameter int VALUE_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  sti_pkg::req_t req,
    input  logic          rsp_stall,
    input  sti_pkg::cmd_t cmd,
    output sti_pkg::sts_t sts,
    output logic          rsp_valid,
    output sti_pkg::rsp_t rsp
);

    localparam int DW  = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int DCW = $clog2(2 * DW + 1);

    logic [1:0]      action_reg;
    logic [DW-1:0]   query_reg;
    logic [DW-1:0]   etemp_reg;
    logic [DW-1:0]   evalue_reg;
    logic [CW-1:0]   count_reg;
    logic [AW-1:0]   lo_reg;
    logic [AW-1:0]   hi_reg;
    logic [AW-1:0]   mid_reg;
    logic [DW-1:0]   key_lo_reg;
    logic [DW-1:0]   val_lo_reg;
    logic [DW-1:0]   key_hi_reg;
    logic [DW-1:0]   val_hi_reg;
    logic [DW-1:0]   span_reg;
    logic [DW-1:0]   off_reg;
    logic [DW-1:0]   dv_reg;
    logic            up_reg;
    logic [2*DW-1:0] div_reg;
    logic [DW-1:0]   rem_reg;
    logic [DCW-1:0]  dcnt_reg;
    logic [DW-1:0]   res_answer_reg;
    logic [2:0]      res_status_reg;
    logic            out_valid_reg;
    logic [31:0]     out_answer_reg;
    logic [2:0]      out_status_reg;

    logic [DW-1:0]   temp_rd;
    logic [DW-1:0]   value_rd;
    logic [DW-1:0]   rd_key;
    logic [DW-1:0]   rd_val;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   gap;
    logic [AW-1:0]   mid_comb;
    logic [CW-1:0]   hi_init;
    logic [DW-1:0]   span_comb;
    logic [DW-1:0]   off_comb;
    logic [DW:0]     rem_sh;
    logic [DW:0]     rem_sub;
    logic            q_bit;
    logic [DW-1:0]   interp;
    logic [DW-1:0]   res_answer_next;
    logic [2:0]      res_status_next;

    sti_ram #(
        .WIDTH (DW),
        .DEPTH (TABLE_DEPTH)
    ) u_temp_ram (
        .clk   (clk),
        .we    (cmd.write_en),
        .waddr (count_reg[AW-1:0]),
        .wdata (etemp_reg),
        .raddr (rd_addr),
        .rdata (temp_rd)
    );

    sti_ram #(
        .WIDTH (DW),
        .DEPTH (TABLE_DEPTH)
    ) u_value_ram (
        .clk   (clk),
        .we    (cmd.write_en),
        .waddr (count_reg[AW-1:0]),
        .wdata (evalue_reg),
        .raddr (rd_addr),
        .rdata (value_rd)
    );

    // swap the columns for an inverse lookup
    assign rd_key = (action_reg == sti_pkg::ACT_FWD) ? temp_rd  : value_rd;
    assign rd_val = (action_reg == sti_pkg::ACT_FWD) ? value_rd : temp_rd;

    assign gap      = hi_reg - lo_reg;
    assign mid_comb = lo_reg + (gap >> 1);
    assign hi_init  = count_reg - CW'(1);

    always_comb
    begin
        case (cmd.rd_sel)
            sti_pkg::RD_LO:  rd_addr = lo_reg;
            sti_pkg::RD_HI:  rd_addr = hi_reg;
            sti_pkg::RD_MID: rd_addr = mid_comb;
            default:         rd_addr = lo_reg;
        endcase
    end

    assign span_comb = key_hi_reg - key_lo_reg;
    assign off_comb  = query_reg - key_lo_reg;

    // one restoring divide step per cycle
    assign rem_sh  = {rem_reg, div_reg[2*DW-1]};
    assign rem_sub = rem_sh - {1'b0, span_reg};
    assign q_bit   = (rem_sh >= {1'b0, span_reg});

    assign interp = up_reg ? (val_lo_reg + div_reg[DW-1:0])
                           : (val_lo_reg - div_reg[DW-1:0]);

    always_comb
    begin
        case (cmd.res_sel)
            sti_pkg::RES_ZERO:
            begin
                res_answer_next = '0;
                res_status_next = sti_pkg::ST_OK;
            end
            sti_pkg::RES_REJECT:
            begin
                res_answer_next = '0;
                res_status_next = sti_pkg::ST_REJECT;
            end
            sti_pkg::RES_EMPTY:
            begin
                res_answer_next = '0;
                res_status_next = sti_pkg::ST_EMPTY;
            end
            sti_pkg::RES_LOW:
            begin
                res_answer_next = val_lo_reg;
                res_status_next = sti_pkg::ST_LOW;
            end
            sti_pkg::RES_HIGH:
            begin
                res_answer_next = rd_val;
                res_status_next = sti_pkg::ST_HIGH;
            end
            sti_pkg::RES_LO_OK:
            begin
                res_answer_next = val_lo_reg;
                res_status_next = sti_pkg::ST_OK;
            end
            sti_pkg::RES_INTERP:
            begin
                res_answer_next = interp;
                res_status_next = sti_pkg::ST_OK;
            end
            default:
            begin
                res_answer_next = '0;
                res_status_next = sti_pkg::ST_OK;
            end
        endcase
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            action_reg <= req.action;
            query_reg  <= req.query[DW-1:0];
            etemp_reg  <= req.entry_temp[DW-1:0];
            evalue_reg <= req.entry_value[DW-1:0];
        end
        if (cmd.init_bounds)
        begin
            lo_reg <= '0;
            hi_reg <= hi_init[AW-1:0];
        end
        if (cmd.cap_lo)
        begin
            key_lo_reg <= rd_key;
            val_lo_reg <= rd_val;
        end
        if (cmd.cap_hi)
        begin
            key_hi_reg <= rd_key;
            val_hi_reg <= rd_val;
        end
        if (cmd.set_mid)
        begin
            mid_reg <= mid_comb;
        end
        if (cmd.bis_step)
        begin
            if (query_reg <= rd_key)
            begin
                hi_reg     <= mid_reg;
                key_hi_reg <= rd_key;
                val_hi_reg <= rd_val;
            end
            else
            begin
                lo_reg     <= mid_reg;
                key_lo_reg <= rd_key;
                val_lo_reg <= rd_val;
            end
        end
        if (cmd.prep)
        begin
            span_reg <= span_comb;
            off_reg  <= (off_comb > span_comb) ? span_comb : off_comb;
            dv_reg   <= (val_hi_reg >= val_lo_reg) ? (val_hi_reg - val_lo_reg)
                                                   : (val_lo_reg - val_hi_reg);
            up_reg   <= (val_hi_reg >= val_lo_reg);
        end
        if (cmd.div_start)
        begin
            div_reg <= {{DW{1'b0}}, dv_reg} * {{DW{1'b0}}, off_reg};
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_reg <= {div_reg[2*DW-2:0], q_bit};
            rem_reg <= q_bit ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        end
        if (cmd.set_res)
        begin
            res_answer_reg <= res_answer_next;
            res_status_reg <= res_status_next;
        end
        if (cmd.out_load)
        begin
            out_answer_reg <= 32'(res_answer_reg);
            out_status_reg <= res_status_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.write_en)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.div_start)
            begin
                dcnt_reg <= DCW'(2 * DW);
            end
            else if (cmd.div_step)
            begin
                dcnt_reg <= dcnt_reg - DCW'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.action    = action_reg;
    assign sts.full      = (count_reg == CW'(TABLE_DEPTH));
    assign sts.empty     = (count_reg == '0);
    assign sts.below     = (query_reg < key_lo_reg);
    assign sts.above     = (query_reg > rd_key);
    assign sts.single    = (hi_reg == lo_reg);
    assign sts.more      = (gap > AW'(1));
    assign sts.zero_span = (key_hi_reg <= key_lo_reg);
    assign sts.div_last  = (dcnt_reg == DCW'(1));
    assign sts.out_free  = !out_valid_reg || !rsp_stall;

    assign rsp_valid  = out_valid_reg;
    assign rsp.answer = out_answer_reg;
    assign rsp.status = out_status_reg;

endmodule

@@ src/sti_ctrl.sv @@
module sti_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  sti_pkg::sts_t sts,
    output sti_pkg::cmd_t cmd
);

    sti_pkg::state_t state_reg;
    sti_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sti_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sti_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = sti_pkg::S_DECODE;
                end
            end
            sti_pkg::S_DECODE:
            begin
                if ((sts.action inside {sti_pkg::ACT_FWD, sti_pkg::ACT_INV}) && !sts.empty)
                begin
                    state_next = sti_pkg::S_RD_LO;
                end
                else
                begin
                    state_next = sti_pkg::S_DONE;
                end
            end
            sti_pkg::S_RD_LO: state_next = sti_pkg::S_RD_HI;
            sti_pkg::S_RD_HI: state_next = sti_pkg::S_CHK;
            sti_pkg::S_CHK:
            begin
                if (sts.below || sts.above || sts.single)
                begin
                    state_next = sti_pkg::S_DONE;
                end
                else
                begin
                    state_next = sti_pkg::S_BIS;
                end
            end
            sti_pkg::S_BIS:
            begin
                state_next = sts.more ? sti_pkg::S_CMP : sti_pkg::S_PREP;
            end
            sti_pkg::S_CMP: state_next = sti_pkg::S_BIS;
            sti_pkg::S_PREP:
            begin
                state_next = sts.zero_span ? sti_pkg::S_DONE : sti_pkg::S_MUL;
            end
            sti_pkg::S_MUL: state_next = sti_pkg::S_DIV;
            sti_pkg::S_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = sti_pkg::S_FIN;
                end
            end
            sti_pkg::S_FIN: state_next = sti_pkg::S_DONE;
            sti_pkg::S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = sti_pkg::S_IDLE;
                end
            end
            default: state_next = sti_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.rd_sel  = sti_pkg::RD_LO;
        cmd.res_sel = sti_pkg::RES_ZERO;
        case (state_reg)
            sti_pkg::S_IDLE:
            begin
                cmd.ready  = 1'b1;
                cmd.accept = req_valid;
            end
            sti_pkg::S_DECODE:
            begin
                cmd.set_res = 1'b1;
                case (sts.action)
                    sti_pkg::ACT_LOAD:
                    begin
                        if (sts.full)
                        begin
                            cmd.res_sel = sti_pkg::RES_REJECT;
                        end
                        else
                        begin
                            cmd.write_en = 1'b1;
                        end
                    end
                    sti_pkg::ACT_FWD, sti_pkg::ACT_INV:
                    begin
                        if (sts.empty)
                        begin
                            cmd.res_sel = sti_pkg::RES_EMPTY;
                        end
                        else
                        begin
                            cmd.set_res     = 1'b0;
                            cmd.init_bounds = 1'b1;
                        end
                    end
                    default: cmd.res_sel = sti_pkg::RES_ZERO;
                endcase
            end
            sti_pkg::S_RD_LO:
            begin
                cmd.rd_sel = sti_pkg::RD_LO;
            end
            sti_pkg::S_RD_HI:
            begin
                cmd.rd_sel = sti_pkg::RD_HI;
                cmd.cap_lo = 1'b1;
            end
            sti_pkg::S_CHK:
            begin
                cmd.cap_hi = 1'b1;
                if (sts.below)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res_sel = sti_pkg::RES_LOW;
                end
                else if (sts.above)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res_sel = sti_pkg::RES_HIGH;
                end
                else if (sts.single)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res_sel = sti_pkg::RES_LO_OK;
                end
            end
            sti_pkg::S_BIS:
            begin
                if (sts.more)
                begin
                    cmd.rd_sel  = sti_pkg::RD_MID;
                    cmd.set_mid = 1'b1;
                end
            end
            sti_pkg::S_CMP:
            begin
                cmd.bis_step = 1'b1;
            end
            sti_pkg::S_PREP:
            begin
                if (sts.zero_span)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res_sel = sti_pkg::RES_LO_OK;
                end
                else
                begin
                    cmd.prep = 1'b1;
                end
            end
            sti_pkg::S_MUL:
            begin
                cmd.div_start = 1'b1;
            end
            sti_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            sti_pkg::S_FIN:
            begin
                cmd.set_res = 1'b1;
                cmd.res_sel = sti_pkg::RES_INTERP;
            end
            sti_pkg::S_DONE:
            begin
                cmd.out_load = sts.out_free;
            end
            default: cmd.ready = 1'b0;
        endcase
    end

endmodule
